FILE: sv/page_frame_free_list_allocator_core_assert.svh
// assertion macros for the frame allocator checker
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// consequent must hold in the same cycle
`define PFFA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pffa port check failed");

// consequent must hold in the following cycle
`define PFFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pffa port check failed");

`endif

FILE: sv/pffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pffa_pkg;

    localparam int FRAME_COUNT = 1024;
    localparam int FRAME_W     = 10;
    localparam int LINK_W      = 11;
    localparam int COUNT_W     = 7;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(FRAME_COUNT);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               wr_en;
        logic [FRAME_W-1:0] wr_addr;
        logic [LINK_W-1:0]  wr_data;
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
    } pffa_ram_req_t;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] frame;
        logic               frame_valid;
        logic               last;
        logic [LINK_W-1:0]  frames_free;
    } pffa_result_t;

endpackage

`default_nettype wire

FILE: sv/page_frame_free_list_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator over a linked free list of 1024 frames, kept in a next-frame
// table in one synchronous RAM plus head and free-count registers. After reset the
// block writes the initial chain into every entry (frame i links to i+1) and holds
// in_ready low during that pass. It then takes one request at a time. A free request,
// a failed or zero-count allocate presents its single result from the execute state
// through the output register, and the block then returns to idle for the next request.
// An allocate of n frames alternates between the issue and wait states and presents
// one frame per pop, since each pop waits for the table read that yields the next head;
// the next request is taken only after the last frame has been pushed.
// Results pass through an output register, so a stalled out_ready only delays the block
// and never loses a result.
module page_frame_free_list_allocator_core #(
    parameter int MAX_ALLOC = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [pffa_pkg::COUNT_W-1:0] alloc_count,
    input  wire logic [pffa_pkg::FRAME_W-1:0] frame_to_free,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             status,
    output logic [pffa_pkg::FRAME_W-1:0]     frame,
    output logic                             frame_valid,
    output logic                             last,
    output logic [pffa_pkg::LINK_W-1:0]      frames_free
);
    import pffa_pkg::*;

    pffa_ram_req_t     ram_req;
    logic [LINK_W-1:0] ram_rd_data;
    pffa_result_t      res;
    logic              push;
    logic              slot_free;

    pffa_ctrl #(
        .MAX_ALLOC (MAX_ALLOC)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .alloc_count   (alloc_count),
        .frame_to_free (frame_to_free),
        .slot_free     (slot_free),
        .push          (push),
        .res           (res),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data)
    );

    pffa_link_ram u_link_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    pffa_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .res         (res),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .frame       (frame),
        .frame_valid (frame_valid),
        .last        (last),
        .frames_free (frames_free)
    );

endmodule

`default_nettype wire

FILE: sv/pffa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pffa_link_ram (
    input  wire logic                    clk,
    input  wire pffa_pkg::pffa_ram_req_t req,
    output logic [pffa_pkg::LINK_W-1:0]  rd_data
);
    import pffa_pkg::*;

    logic [LINK_W-1:0] link_mem [FRAME_COUNT];
    logic [LINK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            link_mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= link_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/pffa_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pffa_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire pffa_pkg::pffa_result_t res,
    output logic                        slot_free,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        status,
    output logic [pffa_pkg::FRAME_W-1:0] frame,
    output logic                        frame_valid,
    output logic                        last,
    output logic [pffa_pkg::LINK_W-1:0] frames_free
);
    import pffa_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    pffa_result_t res_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = push ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = valid_reg;
    assign status      = res_reg.status;
    assign frame       = res_reg.frame;
    assign frame_valid = res_reg.frame_valid;
    assign last        = res_reg.last;
    assign frames_free = res_reg.frames_free;

endmodule

`default_nettype wire

FILE: sv/pffa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pffa_ctrl #(
    parameter int MAX_ALLOC = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [pffa_pkg::COUNT_W-1:0] alloc_count,
    input  wire logic [pffa_pkg::FRAME_W-1:0] frame_to_free,
    input  wire logic                        slot_free,
    output logic                             push,
    output pffa_pkg::pffa_result_t           res,
    output pffa_pkg::pffa_ram_req_t          ram_req,
    input  wire logic [pffa_pkg::LINK_W-1:0] ram_rd_data
);
    import pffa_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    localparam logic [FRAME_W-1:0] LAST_ADDR = FRAME_W'(FRAME_COUNT - 1);
    localparam logic [COUNT_W-1:0] MAX_REQ   = COUNT_W'(MAX_ALLOC);

    logic [2:0]         state_reg,     state_next;
    logic [FRAME_W-1:0] init_addr_reg, init_addr_next;
    logic [LINK_W-1:0]  head_reg,      head_next;
    logic [LINK_W-1:0]  free_reg,      free_next;
    logic [COUNT_W-1:0] remain_reg,    remain_next;
    logic               mode_reg,      mode_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [FRAME_W-1:0] ffree_reg,     ffree_next;

    logic              head_ok;
    logic              ffree_ok;
    logic [LINK_W-1:0] free_inc;
    logic [LINK_W-1:0] free_dec;

    assign head_ok  = head_reg < END_MARK;
    assign ffree_ok = LINK_W'(ffree_reg) < END_MARK;
    assign free_inc = (free_reg < END_MARK) ? free_reg + LINK_W'(1) : free_reg;
    assign free_dec = free_reg - LINK_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        remain_next    = remain_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        ffree_next     = ffree_reg;
        in_ready       = 1'b0;
        push           = 1'b0;
        res            = '0;
        ram_req        = '0;

        case (state_reg)
            ST_INIT:
            begin
                // link table sweep: entry i points at i+1, the top one at the end mark
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = init_addr_reg;
                ram_req.wr_data = LINK_W'(init_addr_reg) + LINK_W'(1);
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + FRAME_W'(1);
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    count_next = alloc_count;
                    ffree_next = frame_to_free;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    if (slot_free)
                    begin
                        push     = 1'b1;
                        res.last = 1'b1;
                        if (ffree_ok)
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = ffree_reg;
                            ram_req.wr_data = head_reg;
                            head_next       = LINK_W'(ffree_reg);
                            free_next       = free_inc;
                            res.status      = STATUS_OK;
                            res.frames_free = free_inc;
                        end
                        else
                        begin
                            res.status      = STATUS_FAIL;
                            res.frames_free = free_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (count_reg > MAX_REQ || LINK_W'(count_reg) > free_reg)
                begin
                    if (slot_free)
                    begin
                        push            = 1'b1;
                        res.status      = STATUS_FAIL;
                        res.last        = 1'b1;
                        res.frames_free = free_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else if (count_reg == '0)
                begin
                    if (slot_free)
                    begin
                        push            = 1'b1;
                        res.status      = STATUS_OK;
                        res.last        = 1'b1;
                        res.frames_free = free_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    remain_next = count_reg;
                    state_next  = ST_ISSUE;
                end
            end

            ST_ISSUE:
            begin
                // fetch the successor of the head frame
                ram_req.rd_en   = head_ok;
                ram_req.rd_addr = head_reg[FRAME_W-1:0];
                state_next      = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (slot_free)
                begin
                    push            = 1'b1;
                    res.status      = STATUS_OK;
                    res.frame       = head_ok ? head_reg[FRAME_W-1:0] : '0;
                    res.frame_valid = head_ok;
                    res.last        = (remain_reg == COUNT_W'(1));
                    res.frames_free = free_dec;
                    free_next       = free_dec;
                    head_next       = head_ok ? ram_rd_data : END_MARK;
                    remain_next     = remain_reg - COUNT_W'(1);
                    state_next      = (remain_reg == COUNT_W'(1)) ? ST_IDLE : ST_ISSUE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            head_reg      <= '0;
            free_reg      <= END_MARK;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        count_reg <= count_next;
        ffree_reg <= ffree_next;
    end

endmodule

`default_nettype wire

FILE: sv/pffa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "page_frame_free_list_allocator_core_assert.svh"

module pffa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         status,
    input wire logic [pffa_pkg::FRAME_W-1:0] frame,
    input wire logic                         frame_valid,
    input wire logic                         last,
    input wire logic [pffa_pkg::LINK_W-1:0]  frames_free
);
    import pffa_pkg::*;

    // count never exceeds the pool
    `PFFA_ASSERT_SAME(a_free_in_range, out_valid, frames_free <= END_MARK)

    // a failed request gives one result and carries no frame
    `PFFA_ASSERT_SAME(a_fail_single, out_valid && status == STATUS_FAIL, last && !frame_valid)

    // no new request is taken while an allocate is still emitting frames
    `PFFA_ASSERT_SAME(a_no_accept_mid_alloc, out_valid && !last, !in_ready)

    // stalled result holds
    `PFFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(frame) && $stable(frames_free) && $stable(last))

endmodule

bind page_frame_free_list_allocator_core pffa_checker u_pffa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .frame       (frame),
    .frame_valid (frame_valid),
    .last        (last),
    .frames_free (frames_free)
);

`default_nettype wire
